### sv/dead_reckoning_odometry_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dead-reckoning odometry block
// Short forms for clocked, reset-qualified property checks.
// ----------------------------------------------------------------------------
`ifndef DEAD_RECKONING_ODOMETRY_TOP_ASSERT_SVH
`define DEAD_RECKONING_ODOMETRY_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DRO_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DRO_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/dro_pkg.sv
// ----------------------------------------------------------------------------
// dro_pkg
// Types, widths, constants and tables shared by the odometry block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dro_pkg;

  // Field widths
  localparam int COUNT_W    = 32;
  localparam int HEAD_W     = 16;
  localparam int SCALE_W    = 16;
  localparam int POS_W      = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_CALIBRATED   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_MM = 1'b1;

  // Item kinds
  localparam logic KIND_INIT = 1'b0;

  // Distance path: D = round(S * 2^FRAC_SHIFT / T)
  localparam int UNIT_SCALE = 256;
  localparam int SUM_W      = COUNT_W + 1;
  localparam int FRAC_SHIFT = 11;
  localparam int NUM_W      = SUM_W + FRAC_SHIFT;

  // Heading path, angles in 0.005 degree units
  localparam int ANG_W        = 18;
  localparam int QUARTER_TURN = 18000;
  localparam int HALF_TURN    = 36000;
  localparam int TURN_MAX     = 9;
  localparam int TURN_IDX_W   = 4;
  localparam int R_W          = 15;

  // r * 8192 / 25 = r * Z_INT + floor(r * Z_FRAC / 25), reciprocal form
  localparam int Z_INT      = 327;
  localparam int Z_FRAC     = 17;
  localparam int Z_RECIP    = 671089;
  localparam int Z_FRAC_MUL = Z_FRAC * Z_RECIP;
  localparam int Z_SHIFT    = 24;
  localparam int ZP_W       = 39;

  // CORDIC
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = 4;
  localparam int ATAN_W       = 22;
  localparam int Z_W          = 26;
  localparam int CORD_W       = 34;
  localparam logic signed [CORD_W-1:0] CORDIC_X0 = 34'sd652032874;
  localparam int Q16_ROUND    = 8192;
  localparam int Q16_SHIFT    = 14;
  localparam int FAC_W        = 18;

  // Position update
  localparam int HALF_W    = NUM_W / 2;
  localparam int PROD_W    = HALF_W + FAC_W;
  localparam int MAG_W     = NUM_W + FAC_W;
  localparam int POS_ROUND = 32768;
  localparam int POS_SHIFT = 16;
  localparam int RND_W     = MAG_W - POS_SHIFT;
  localparam int DELTA_W   = RND_W + 1;
  localparam int SAT_W     = DELTA_W + 1;

  typedef struct packed {
    logic                      kind;
    logic signed [COUNT_W-1:0] left_count;
    logic signed [COUNT_W-1:0] right_count;
    logic [HEAD_W-1:0]         heading_cdeg;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
  } out_item_t;

  // Cosine and sine as magnitude and sign, Q16
  typedef struct packed {
    logic [FAC_W-1:0] c_mag;
    logic             c_neg;
    logic [FAC_W-1:0] s_mag;
    logic             s_neg;
  } trig_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cord_stat_t;

  // Arctangent of 2^-i in degrees * 2^16
  function automatic logic [ATAN_W-1:0] atan_deg16(input logic [STEP_W-1:0] idx);
    logic [ATAN_W-1:0] val;
    case (idx)
      4'd0:    val = 22'd2949120;
      4'd1:    val = 22'd1740967;
      4'd2:    val = 22'd919879;
      4'd3:    val = 22'd466945;
      4'd4:    val = 22'd234379;
      4'd5:    val = 22'd117304;
      4'd6:    val = 22'd58666;
      4'd7:    val = 22'd29335;
      4'd8:    val = 22'd14668;
      4'd9:    val = 22'd7334;
      4'd10:   val = 22'd3667;
      4'd11:   val = 22'd1833;
      4'd12:   val = 22'd917;
      4'd13:   val = 22'd458;
      4'd14:   val = 22'd229;
      4'd15:   val = 22'd115;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

### sv/dro_cordic.sv
// ----------------------------------------------------------------------------
// dro_cordic
// Iterative CORDIC giving cosine and sine in Q16 of an angle in 0.005 degree.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dro_cordic (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [dro_pkg::ANG_W-1:0]   ang_i,
  output dro_pkg::trig_t              trig_o,
  output dro_pkg::cord_stat_t         stat_o
);

  localparam int SEQ_ZPROD  = 0;
  localparam int SEQ_ZINIT  = 1;
  localparam int SEQ_ITER   = 2;
  localparam int SEQ_FINISH = SEQ_ITER + dro_pkg::CORDIC_STEPS;
  localparam int SEQ_W      = $clog2(SEQ_FINISH + 1);

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  logic                                  busy_q, done_q;
  logic [SEQ_W-1:0]                      seq_q;
  logic [1:0]                            quad_q;
  logic [dro_pkg::R_W-1:0]               r_q;
  logic [dro_pkg::ZP_W-1:0]              zp_q;
  logic signed [dro_pkg::CORD_W-1:0]     x_q, y_q;
  logic signed [dro_pkg::Z_W-1:0]        z_q;
  dro_pkg::trig_t                        trig_q, trig_d;

  logic [dro_pkg::TURN_IDX_W-1:0]        turn_k;
  logic [dro_pkg::ANG_W-1:0]             turn_base;
  logic [dro_pkg::R_W-1:0]               r_red;
  logic [dro_pkg::STEP_W-1:0]            it_idx;
  logic signed [dro_pkg::CORD_W-1:0]     xs, ys, rx, ry;
  logic signed [dro_pkg::Z_W-1:0]        atan_z;
  logic [dro_pkg::FAC_W-1:0]             cq, sq;

  // Quarter-turn index by parallel compares; the angle is below ten quarter turns.
  always_comb begin
    turn_k    = '0;
    turn_base = '0;
    for (int j = 1; j <= dro_pkg::TURN_MAX; j++) begin
      if (ang_i >= dro_pkg::ANG_W'(j * dro_pkg::QUARTER_TURN)) begin
        turn_k    = dro_pkg::TURN_IDX_W'(j);
        turn_base = dro_pkg::ANG_W'(j * dro_pkg::QUARTER_TURN);
      end
    end
  end

  assign r_red  = dro_pkg::R_W'(ang_i - turn_base);
  assign it_idx = dro_pkg::STEP_W'(seq_q - SEQ_W'(SEQ_ITER));
  assign xs     = x_q >>> it_idx;
  assign ys     = y_q >>> it_idx;
  assign atan_z = $signed(dro_pkg::Z_W'(dro_pkg::atan_deg16(it_idx)));

  // Round to Q16 (floor of the shifted sum), negative results clamp to zero.
  assign rx = (x_q + dro_pkg::CORD_W'(dro_pkg::Q16_ROUND)) >>> dro_pkg::Q16_SHIFT;
  assign ry = (y_q + dro_pkg::CORD_W'(dro_pkg::Q16_ROUND)) >>> dro_pkg::Q16_SHIFT;
  assign cq = rx[dro_pkg::CORD_W-1] ? '0 : rx[dro_pkg::FAC_W-1:0];
  assign sq = ry[dro_pkg::CORD_W-1] ? '0 : ry[dro_pkg::FAC_W-1:0];

  always_comb begin
    trig_d = '0;
    case (quad_q)
      QUAD_0: begin
        trig_d.c_mag = cq; trig_d.c_neg = 1'b0;
        trig_d.s_mag = sq; trig_d.s_neg = 1'b0;
      end
      QUAD_1: begin
        trig_d.c_mag = sq; trig_d.c_neg = 1'b1;
        trig_d.s_mag = cq; trig_d.s_neg = 1'b0;
      end
      QUAD_2: begin
        trig_d.c_mag = cq; trig_d.c_neg = 1'b1;
        trig_d.s_mag = sq; trig_d.s_neg = 1'b1;
      end
      QUAD_3: begin
        trig_d.c_mag = sq; trig_d.c_neg = 1'b0;
        trig_d.s_mag = cq; trig_d.s_neg = 1'b1;
      end
      default: trig_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      seq_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      seq_q  <= '0;
    end else if (busy_q) begin
      seq_q <= seq_q + 1'b1;
      if (seq_q == SEQ_W'(SEQ_FINISH)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quad_q <= turn_k[1:0];
      r_q    <= r_red;
    end else if (busy_q) begin
      if (seq_q == SEQ_W'(SEQ_ZPROD)) begin
        zp_q <= dro_pkg::ZP_W'(r_q) * dro_pkg::ZP_W'(dro_pkg::Z_FRAC_MUL);
      end else if (seq_q == SEQ_W'(SEQ_ZINIT)) begin
        z_q <= $signed(dro_pkg::Z_W'(r_q) * dro_pkg::Z_W'(dro_pkg::Z_INT)
                       + dro_pkg::Z_W'(zp_q >> dro_pkg::Z_SHIFT));
        x_q <= dro_pkg::CORDIC_X0;
        y_q <= '0;
      end else if (seq_q == SEQ_W'(SEQ_FINISH)) begin
        trig_q <= trig_d;
      end else if (!z_q[dro_pkg::Z_W-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - atan_z;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + atan_z;
      end
    end
  end

  assign trig_o      = trig_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

`default_nettype wire

### sv/dead_reckoning_odometry_top.sv
// An update item passes DELTA, the 44-step restoring divider with the CORDIC inside it, the
// multiplier steps and DONE; an init item goes from DELTA straight to DONE. No new item is
// taken until the last one's result has been handed to the output register.
// A finished result waits in the output register while the next item is taken.
// Reset (asynchronous, active low) clears the position, the last sample and the
// configuration registers (uncalibrated, scale 1.0); an item is taken from the first edge.
// ----------------------------------------------------------------------------
// dead_reckoning_odometry_top
// Differential-drive odometry from wheel encoder counts and a compass heading.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "dead_reckoning_odometry_top_assert.svh"

module dead_reckoning_odometry_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  dro_pkg::in_item_t                 in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output dro_pkg::out_item_t                out_item_o,
  input  logic                              cfg_we_i,
  input  logic [dro_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [dro_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  // Sequencer states. An update item runs DELTA, CALC, MUL and DONE in turn;
  // an init item goes straight from DELTA to DONE.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DELTA = 3'd1;
  localparam logic [2:0] ST_CALC  = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  // The step counter covers one setup step and then one quotient bit per cycle.
  localparam int CNT_W = $clog2(dro_pkg::NUM_W + 1);
  localparam logic [CNT_W-1:0] CALC_LAST = CNT_W'(dro_pkg::NUM_W);

  // Steps of the position update, run once for X and once for Y.
  localparam logic [CNT_W-1:0] MS_LO  = CNT_W'(0);
  localparam logic [CNT_W-1:0] MS_HI  = CNT_W'(1);
  localparam logic [CNT_W-1:0] MS_ADD = CNT_W'(2);
  localparam logic [CNT_W-1:0] MS_RND = CNT_W'(3);
  localparam logic [CNT_W-1:0] MS_NEG = CNT_W'(4);
  localparam logic [CNT_W-1:0] MS_SAT = CNT_W'(5);

  localparam logic signed [dro_pkg::SAT_W-1:0] SAT_HI =
    {{(dro_pkg::SAT_W - dro_pkg::POS_W + 1){1'b0}}, {(dro_pkg::POS_W - 1){1'b1}}};
  localparam logic signed [dro_pkg::SAT_W-1:0] SAT_LO =
    {{(dro_pkg::SAT_W - dro_pkg::POS_W + 1){1'b1}}, {(dro_pkg::POS_W - 1){1'b0}}};

  // Control and model state
  logic [2:0]                              state_q, state_d;
  logic [CNT_W-1:0]                        cnt_q, cnt_d;
  logic                                    coord_q, coord_d;
  logic                                    cal_q;
  logic [dro_pkg::SCALE_W-1:0]             tpm_q;
  logic [dro_pkg::COUNT_W-1:0]             prev_left_q, prev_left_d;
  logic [dro_pkg::COUNT_W-1:0]             prev_right_q, prev_right_d;
  logic [dro_pkg::HEAD_W-1:0]              prev_head_q, prev_head_d;
  logic signed [dro_pkg::POS_W-1:0]        acc_x_q, acc_x_d, acc_y_q, acc_y_d;
  logic                                    out_valid_q, out_valid_d;

  // Datapath registers
  dro_pkg::in_item_t                       item_q, item_d;
  dro_pkg::out_item_t                      out_q, out_d;
  logic signed [dro_pkg::SUM_W-1:0]        sum_q, sum_d;
  logic [dro_pkg::ANG_W-1:0]               ang_q, ang_d;
  logic [dro_pkg::NUM_W-1:0]               num_q, num_d;
  logic [dro_pkg::SCALE_W-1:0]             rem_q, rem_d;
  logic                                    dneg_q, dneg_d;
  logic [dro_pkg::PROD_W-1:0]              prod_q, prod_d;
  logic [dro_pkg::MAG_W-1:0]               mag_q, mag_d;
  logic [dro_pkg::RND_W-1:0]               rnd_q, rnd_d;
  logic signed [dro_pkg::DELTA_W-1:0]      delta_q, delta_d;

  // Combinational helpers
  logic [dro_pkg::SCALE_W-1:0]             t_scale;
  logic [dro_pkg::COUNT_W-1:0]             dl, dr;
  logic                                    turn_wrap;
  logic [dro_pkg::SUM_W-1:0]               smag;
  logic [dro_pkg::SCALE_W:0]               trial;
  logic                                    trial_ge;
  logic [dro_pkg::HALF_W-1:0]              mul_half;
  logic [dro_pkg::FAC_W-1:0]               fac;
  logic                                    fac_neg;
  logic [dro_pkg::MAG_W-1:0]               mag_rnd;
  logic signed [dro_pkg::POS_W-1:0]        acc_sel, acc_new;
  logic signed [dro_pkg::SAT_W-1:0]        sat_sum;

  logic                                    cord_start;
  dro_pkg::trig_t                          trig;
  dro_pkg::cord_stat_t                     cord_stat;

  // Configuration registers. The user must write them only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= 1'b0;
      tpm_q <= dro_pkg::SCALE_W'(dro_pkg::UNIT_SCALE);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dro_pkg::CFG_CALIBRATED:   cal_q <= cfg_wdata_i[0];
        dro_pkg::CFG_TICKS_PER_MM: tpm_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // A zero scale or an uncalibrated setting means one tick per millimetre (Q8.8 1.0).
  assign t_scale = (cal_q && (tpm_q != '0)) ? tpm_q
                                            : dro_pkg::SCALE_W'(dro_pkg::UNIT_SCALE);

  // Encoder deltas wrap modulo 2^32 and are read as signed.
  assign dl = dro_pkg::COUNT_W'(item_q.left_count - prev_left_q);
  assign dr = dro_pkg::COUNT_W'(item_q.right_count - prev_right_q);

  // The circular mean needs a half turn added when the two headings lie more
  // than 180 degrees apart; exactly 180 degrees apart adds nothing.
  assign turn_wrap =
    ({1'b0, item_q.heading_cdeg} >
       ({1'b0, prev_head_q} + (dro_pkg::HEAD_W + 1)'(dro_pkg::QUARTER_TURN))) ||
    ({1'b0, prev_head_q} >
       ({1'b0, item_q.heading_cdeg} + (dro_pkg::HEAD_W + 1)'(dro_pkg::QUARTER_TURN)));

  // Magnitude of the tick sum; the most negative sum maps to 2^32 as it should.
  assign smag = sum_q[dro_pkg::SUM_W-1] ? dro_pkg::SUM_W'(-sum_q) : dro_pkg::SUM_W'(sum_q);

  // One restoring division step: shift in the next numerator bit and try T.
  assign trial    = {rem_q, num_q[dro_pkg::NUM_W-1]};
  assign trial_ge = trial >= {1'b0, t_scale};

  // The distance magnitude is multiplied in two halves by the Q16 factor.
  assign mul_half = (cnt_q == MS_LO) ? num_q[dro_pkg::HALF_W-1:0]
                                     : num_q[dro_pkg::NUM_W-1:dro_pkg::HALF_W];
  assign fac      = coord_q ? trig.s_mag : trig.c_mag;
  assign fac_neg  = coord_q ? trig.s_neg : trig.c_neg;
  assign mag_rnd  = mag_q + dro_pkg::MAG_W'(dro_pkg::POS_ROUND);

  // Saturating add of the rounded step to the selected coordinate.
  assign acc_sel = coord_q ? acc_y_q : acc_x_q;
  assign sat_sum = {{(dro_pkg::SAT_W - dro_pkg::POS_W){acc_sel[dro_pkg::POS_W-1]}}, acc_sel}
                 + {delta_q[dro_pkg::DELTA_W-1], delta_q};
  assign acc_new = (sat_sum > SAT_HI) ? SAT_HI[dro_pkg::POS_W-1:0] :
                   (sat_sum < SAT_LO) ? SAT_LO[dro_pkg::POS_W-1:0] :
                                        sat_sum[dro_pkg::POS_W-1:0];

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    coord_d      = coord_q;
    prev_left_d  = prev_left_q;
    prev_right_d = prev_right_q;
    prev_head_d  = prev_head_q;
    acc_x_d      = acc_x_q;
    acc_y_d      = acc_y_q;
    item_d       = item_q;
    sum_d        = sum_q;
    ang_d        = ang_q;
    num_d        = num_q;
    rem_d        = rem_q;
    dneg_d       = dneg_q;
    prod_d       = prod_q;
    mag_d        = mag_q;
    rnd_d        = rnd_q;
    delta_d      = delta_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    cord_start   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_item_i;
          state_d = ST_DELTA;
        end
      end

      // Form the tick sum and the doubled heading, and take the new sample as
      // the last one. An init item only clears the position.
      ST_DELTA: begin
        sum_d = $signed({dl[dro_pkg::COUNT_W-1], dl}) + $signed({dr[dro_pkg::COUNT_W-1], dr});
        ang_d = dro_pkg::ANG_W'(item_q.heading_cdeg) + dro_pkg::ANG_W'(prev_head_q)
              + (turn_wrap ? dro_pkg::ANG_W'(dro_pkg::HALF_TURN) : '0);
        prev_left_d  = item_q.left_count;
        prev_right_d = item_q.right_count;
        prev_head_d  = item_q.heading_cdeg;
        if (item_q.kind == dro_pkg::KIND_INIT) begin
          acc_x_d = '0;
          acc_y_d = '0;
          state_d = ST_DONE;
        end else begin
          cnt_d   = '0;
          state_d = ST_CALC;
        end
      end

      // Step 0 loads the divider and starts the CORDIC; then one quotient bit
      // per cycle. The CORDIC finishes well inside the division.
      ST_CALC: begin
        if (cnt_q == '0) begin
          dneg_d     = sum_q[dro_pkg::SUM_W-1];
          num_d      = {smag, {dro_pkg::FRAC_SHIFT{1'b0}}}
                     + dro_pkg::NUM_W'(t_scale >> 1);
          rem_d      = '0;
          cord_start = 1'b1;
        end else begin
          num_d = {num_q[dro_pkg::NUM_W-2:0], trial_ge};
          rem_d = trial_ge ? dro_pkg::SCALE_W'(trial - {1'b0, t_scale})
                           : trial[dro_pkg::SCALE_W-1:0];
        end
        if (cnt_q == CALC_LAST) begin
          cnt_d   = '0;
          coord_d = 1'b0;
          state_d = ST_MUL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      // X first, then Y: two partial products, their sum, rounding of the
      // magnitude, the sign, and the saturating add.
      ST_MUL: begin
        cnt_d = cnt_q + 1'b1;
        case (cnt_q)
          MS_LO: begin
            prod_d = dro_pkg::PROD_W'(mul_half) * dro_pkg::PROD_W'(fac);
          end
          MS_HI: begin
            mag_d  = dro_pkg::MAG_W'(prod_q);
            prod_d = dro_pkg::PROD_W'(mul_half) * dro_pkg::PROD_W'(fac);
          end
          MS_ADD: begin
            mag_d = mag_q + (dro_pkg::MAG_W'(prod_q) << dro_pkg::HALF_W);
          end
          MS_RND: begin
            rnd_d = mag_rnd[dro_pkg::MAG_W-1:dro_pkg::POS_SHIFT];
          end
          MS_NEG: begin
            delta_d = (dneg_q ^ fac_neg) ? -$signed({1'b0, rnd_q}) : $signed({1'b0, rnd_q});
          end
          MS_SAT: begin
            cnt_d = '0;
            if (coord_q) begin
              acc_y_d = acc_new;
              state_d = ST_DONE;
            end else begin
              acc_x_d = acc_new;
              coord_d = 1'b1;
            end
          end
          default: cnt_d = '0;
        endcase
      end

      // Hand the position to the output register once it is free.
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.pos_x = acc_x_q;
          out_d.pos_y = acc_y_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      coord_q      <= 1'b0;
      prev_left_q  <= '0;
      prev_right_q <= '0;
      prev_head_q  <= '0;
      acc_x_q      <= '0;
      acc_y_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      coord_q      <= coord_d;
      prev_left_q  <= prev_left_d;
      prev_right_q <= prev_right_d;
      prev_head_q  <= prev_head_d;
      acc_x_q      <= acc_x_d;
      acc_y_q      <= acc_y_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    sum_q   <= sum_d;
    ang_q   <= ang_d;
    num_q   <= num_d;
    rem_q   <= rem_d;
    dneg_q  <= dneg_d;
    prod_q  <= prod_d;
    mag_q   <= mag_d;
    rnd_q   <= rnd_d;
    delta_q <= delta_d;
    out_q   <= out_d;
  end

  dro_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .ang_i   (ang_q),
    .trig_o  (trig),
    .stat_o  (cord_stat)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // The CORDIC result must be ready by the last division step.
  `DRO_ASSERT_IMPL(a_cordic_ready, (state_q == ST_CALC) && (cnt_q == CALC_LAST), cord_stat.done, "CORDIC not finished when division ends")
  // A finished division leaves a remainder below the divisor.
  `DRO_ASSERT_IMPL(a_div_rem, state_q == ST_MUL, rem_q < t_scale, "division remainder out of range")
  // The CORDIC sequencer is never left running once the block is idle.
  `DRO_ASSERT_IMPL(a_cordic_idle, state_q == ST_IDLE, !cord_stat.busy, "CORDIC busy while idle")
  // The position changes only while an item is being worked on.
  `DRO_ASSERT_NEXT(a_acc_hold, (state_q != ST_MUL) && (state_q != ST_DELTA), $stable(acc_x_q) && $stable(acc_y_q), "position changed outside an update")

endmodule

`default_nettype wire

### dv/dead_reckoning_odometry_top_test.sv
// ----------------------------------------------------------------------------
// dead_reckoning_odometry_top_test
// Self-checking bench for the odometry block. A short table of directed items
// covers initialisation, heading wrap, the half-turn rule, counter wrap and
// position saturation. Random encoder tracks then run under several scale
// settings and idling patterns. Each result is compared with a
// cycle-independent position predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dead_reckoning_odometry_top_test;
  import dro_pkg::*;

  // The package names only the init kind; an update is the other value.
  localparam logic KIND_UPDATE = ~KIND_INIT;
  localparam int   FULL_TURN   = 2 * HALF_TURN;

  localparam int PHASE_ITEMS = 150;
  localparam int N_PHASES    = 6;
  localparam int NOISE_PCT   = 12;
  localparam int INIT_PCT    = 6;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 80;
  localparam int MAX_REPORTS = 10;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  dead_reckoning_odometry_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 20 ns clock period.
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Position predictor
  // --------------------------------------------------------------------------
  // The bench keeps its own copy of the two registers and of the block state.
  // Everything is worked out in 64-bit signed arithmetic, which holds the
  // widest intermediate (distance times a Q16 factor) with room to spare.

  logic                    cal_model;
  logic [SCALE_W-1:0]      scale_model;
  logic [COUNT_W-1:0]      last_left;
  logic [COUNT_W-1:0]      last_right;
  logic [HEAD_W-1:0]       last_heading;
  logic signed [POS_W-1:0] track_x;
  logic signed [POS_W-1:0] track_y;

  // Arctangent of 2^-i in degrees scaled by 2^16.
  longint arc_deg16 [CORDIC_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  // Division rounded to nearest, with ties going away from zero.
  function automatic longint round_div(longint n, longint d);
    if (n >= 0) begin
      return (n + d / 2) / d;
    end
    return -((-n + d / 2) / d);
  endfunction

  function automatic logic signed [POS_W-1:0] clamp_add(logic signed [POS_W-1:0] p,
                                                        longint d);
    longint r;
    r = longint'(p) + d;
    if (r > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end
    if (r < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return r[POS_W-1:0];
  endfunction

  // Q30 CORDIC output to Q16, rounded, never below zero.
  function automatic longint q16_of(longint v);
    longint r;
    r = (v + Q16_ROUND) >>> Q16_SHIFT;
    return (r < 0) ? 0 : r;
  endfunction

  // Cosine and sine in Q16 of an angle in units of 0.005 degree. The first
  // quadrant is rotated by CORDIC and the quadrant only swaps and negates.
  function automatic void compass_trig(input int unsigned ang,
                                       output longint c, output longint s);
    int unsigned a;
    int unsigned quad;
    int unsigned rem;
    longint z;
    longint x;
    longint y;
    longint xs;
    longint ys;
    longint cq;
    longint sq;
    a    = ang % FULL_TURN;
    quad = a / QUARTER_TURN;
    rem  = a % QUARTER_TURN;
    z    = longint'(rem) * 8192 / 25;
    x    = longint'(CORDIC_X0);
    y    = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - arc_deg16[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + arc_deg16[i];
      end
    end
    cq = q16_of(x);
    sq = q16_of(y);
    case (quad)
      0: begin
        c = cq;
        s = sq;
      end
      1: begin
        c = -sq;
        s = cq;
      end
      2: begin
        c = -cq;
        s = -sq;
      end
      default: begin
        c = sq;
        s = -cq;
      end
    endcase
  endfunction

  // Applies one item to the predicted state and returns the position after it.
  function automatic out_item_t advance_position(in_item_t it);
    logic [COUNT_W-1:0] dl;
    logic [COUNT_W-1:0] dr;
    longint sum;
    longint scale;
    longint travel;
    longint diff;
    longint c;
    longint s;
    int unsigned ang;
    out_item_t res;
    if (it.kind == KIND_INIT) begin
      track_x = '0;
      track_y = '0;
    end else begin
      // Encoder deltas are modular, so a counter wrap is a small step.
      dl     = it.left_count - last_left;
      dr     = it.right_count - last_right;
      sum    = longint'($signed(dl)) + longint'($signed(dr));
      scale  = (cal_model && scale_model != '0) ? longint'(scale_model) : UNIT_SCALE;
      travel = round_div(sum * (64'sd1 <<< FRAC_SHIFT), scale);
      // Circular mean of the two headings: a gap wider than half a turn
      // means the plain mean points the wrong way.
      diff  = longint'(it.heading_cdeg) - longint'(last_heading);
      ang   = int'(it.heading_cdeg) + int'(last_heading);
      if (diff > QUARTER_TURN || diff < -QUARTER_TURN) begin
        ang += HALF_TURN;
      end
      compass_trig(ang, c, s);
      track_x = clamp_add(track_x, round_div(travel * c, 64'sd1 <<< POS_SHIFT));
      track_y = clamp_add(track_y, round_div(travel * s, 64'sd1 <<< POS_SHIFT));
    end
    last_left    = it.left_count;
    last_right   = it.right_count;
    last_heading = it.heading_cdeg;
    res.pos_x    = track_x;
    res.pos_y    = track_y;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  // Expected positions in acceptance order. The block answers every item
  // exactly once and in order, so the oldest entry always belongs to the
  // next result.

  out_item_t pending_pos[$];
  int        fail_count;

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%0t ns: %s", $time, msg);
    end
  endfunction

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pos.size() == 0) begin
        note_failure($sformatf("result (%0d, %0d) arrived with nothing outstanding",
                               out_item_o.pos_x, out_item_o.pos_y));
      end else begin
        want = pending_pos.pop_front();
        if (out_item_o.pos_x !== want.pos_x) begin
          note_failure($sformatf("pos_x: expected %0d, got %0d",
                                 want.pos_x, out_item_o.pos_x));
        end
        if (out_item_o.pos_y !== want.pos_y) begin
          note_failure($sformatf("pos_y: expected %0d, got %0d",
                                 want.pos_y, out_item_o.pos_y));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver
  // --------------------------------------------------------------------------
  // The stall is decided at each falling edge. A hold-off request from the
  // stimulus process overrides the random pattern and is counted down here,
  // cycle by cycle, so that the sender keeps offering items meanwhile and the
  // block backs up into its input.

  int dst_idle_pct;
  int src_idle_pct;
  int hold_left;

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < dst_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Sender and configuration
  // --------------------------------------------------------------------------

  // Offers one item, with random gaps ahead of it, and holds it until taken.
  // Valid stays high after acceptance; the next call replaces or drops it, the drain drops it,
  // always at a later falling edge. Rows whose result is obvious push the
  // typed value; the predictor still runs so that its state stays in step.
  task automatic offer_item(in_item_t it, bit known, out_item_t want);
    out_item_t pred;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    pred = advance_position(it);
    pending_pos.push_back(known ? want : pred);
  endtask

  // The sender stops and waits for every outstanding result. Since each item
  // gives exactly one result, the block is idle once the queue is empty.
  task automatic drain_positions();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_pos.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx == CFG_CALIBRATED) begin
      cal_model = val[0];
    end else begin
      scale_model = val[SCALE_W-1:0];
    end
  endtask

  task automatic apply_scale(logic cal, logic [SCALE_W-1:0] ticks);
    write_reg(CFG_CALIBRATED, CFG_DATA_W'(cal));
    write_reg(CFG_TICKS_PER_MM, ticks);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Directed rows
  // --------------------------------------------------------------------------

  typedef struct {
    in_item_t  stim;
    bit        known;
    out_item_t want;
  } drive_row_t;

  drive_row_t drive_rows[$];

  function automatic void add_row(logic kind, logic [COUNT_W-1:0] l, logic [COUNT_W-1:0] r,
                                  logic [HEAD_W-1:0] h, bit known);
    drive_row_t row;
    row.stim.kind         = kind;
    row.stim.left_count   = l;
    row.stim.right_count  = r;
    row.stim.heading_cdeg = h;
    row.known             = known;
    row.want.pos_x        = '0;
    row.want.pos_y        = '0;
    drive_rows.push_back(row);
  endfunction

  // --------------------------------------------------------------------------
  // Random encoder tracks
  // --------------------------------------------------------------------------
  // Most items follow a plausible robot: an init, then updates with modest
  // wheel steps and a heading that drifts and wraps through north. A few
  // steps jump the counters anywhere, a few re-initialise, and some items are
  // pure noise with every field random, the heading beyond its range too.

  logic [COUNT_W-1:0] run_left;
  logic [COUNT_W-1:0] run_right;
  int                 run_head;

  task automatic run_phase(int n_items, int hold_at);
    in_item_t  it;
    out_item_t none;
    int        roll;
    none = '0;
    for (int i = 0; i < n_items; i++) begin
      if (i == hold_at) begin
        hold_left = HOLD_CYCLES;
      end
      // Half-way through, the sender pauses until all results are back.
      if (i == n_items / 2) begin
        drain_positions();
      end
      roll = $urandom_range(99);
      if (roll < NOISE_PCT) begin
        it.kind         = 1'($urandom_range(1));
        it.left_count   = $urandom;
        it.right_count  = $urandom;
        it.heading_cdeg = HEAD_W'($urandom_range(16'hffff));
        run_left  = it.left_count;
        run_right = it.right_count;
        run_head  = it.heading_cdeg % (HALF_TURN / 2 * 2);
      end else if (i == 0 || roll < NOISE_PCT + INIT_PCT) begin
        run_left        = $urandom;
        run_right       = $urandom;
        run_head        = $urandom_range(35999);
        it.kind         = KIND_INIT;
        it.left_count   = run_left;
        it.right_count  = run_right;
        it.heading_cdeg = HEAD_W'(run_head);
      end else begin
        if ($urandom_range(99) < 5) begin
          run_left  = $urandom;
          run_right = $urandom;
        end else begin
          run_left  = run_left + COUNT_W'($urandom_range(2000)) - COUNT_W'(1000);
          run_right = run_right + COUNT_W'($urandom_range(2000)) - COUNT_W'(1000);
        end
        if ($urandom_range(99) < 10) begin
          run_head = $urandom_range(35999);
        end else begin
          run_head = (run_head + $urandom_range(6000) + 33000) % 36000;
        end
        it.kind         = KIND_UPDATE;
        it.left_count   = run_left;
        it.right_count  = run_right;
        it.heading_cdeg = HEAD_W'(run_head);
      end
      offer_item(it, 1'b0, none);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    out_item_t none;
    logic      ph_cal [N_PHASES];
    int        ph_ticks [N_PHASES];
    none         = '0;
    fail_count   = 0;
    hold_left    = 0;
    src_idle_pct = 12;
    dst_idle_pct = 56;

    // Predictor state matches the block after reset.
    cal_model    = 1'b0;
    scale_model  = SCALE_W'(UNIT_SCALE);
    last_left    = '0;
    last_right   = '0;
    last_heading = '0;
    track_x      = '0;
    track_y      = '0;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_stall_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_CALIBRATED;
    cfg_wdata_i = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, under the reset scale (uncalibrated, 1.0).
    // An init always clears the position, so its result is typed in.
    add_row(KIND_INIT,   32'h0, 32'h0, 16'd0, 1'b1);
    // No wheel movement: the position cannot change.
    add_row(KIND_UPDATE, 32'h0, 32'h0, 16'd0, 1'b1);
    add_row(KIND_UPDATE, 32'd1000, 32'd1000, 16'd0, 1'b0);
    add_row(KIND_UPDATE, 32'd3000, 32'd1000, 16'd9000, 1'b0);
    // Headings more than half a turn apart, then exactly half a turn apart.
    add_row(KIND_UPDATE, 32'd3000, 32'd5000, 16'd35999, 1'b0);
    add_row(KIND_UPDATE, 32'd4000, 32'd6000, 16'd17999, 1'b0);
    add_row(KIND_UPDATE, 32'd4100, 32'd6100, 16'd0, 1'b0);
    // Headings past the compass range are taken modulo a full turn.
    add_row(KIND_UPDATE, 32'd4200, 32'd6200, 16'hffff, 1'b0);
    add_row(KIND_UPDATE, 32'd4300, 32'd6300, 16'd36000, 1'b0);
    // Counters wrap: steps of +1 and -1 cancel, so nothing moves.
    add_row(KIND_INIT,   32'h7fffffff, 32'h80000000, 16'd18000, 1'b1);
    add_row(KIND_UPDATE, 32'h80000000, 32'h7fffffff, 16'd18000, 1'b1);
    // Largest backward steps on both wheels: X saturates high, Y low, then
    // X is driven down to its low limit.
    add_row(KIND_UPDATE, 32'h0, 32'hffffffff, 16'd18000, 1'b0);
    add_row(KIND_UPDATE, 32'h80000000, 32'h7fffffff, 16'd0, 1'b0);
    add_row(KIND_UPDATE, 32'h0, 32'hffffffff, 16'd0, 1'b0);
    add_row(KIND_UPDATE, 32'h7fffffff, 32'h80000000, 16'd27000, 1'b0);
    add_row(KIND_INIT,   32'hffffffff, 32'h00000000, 16'hffff, 1'b1);
    add_row(KIND_UPDATE, 32'h00001234, 32'hfffff000, 16'd0, 1'b0);
    add_row(KIND_UPDATE, 32'h00002000, 32'hffffe000, 16'd26999, 1'b0);
    foreach (drive_rows[k]) begin
      offer_item(drive_rows[k].stim, drive_rows[k].known, drive_rows[k].want);
    end
    drain_positions();

    // Scale settings per random phase: smallest and largest calibrated
    // scale, a zero scale (taken as 1.0), an ignored scale while
    // uncalibrated, a typical one, and finally the reset values again.
    ph_cal[0] = 1'b1;  ph_ticks[0] = 1;
    ph_cal[1] = 1'b1;  ph_ticks[1] = 65535;
    ph_cal[2] = 1'b1;  ph_ticks[2] = 0;
    ph_cal[3] = 1'b0;  ph_ticks[3] = 12345;
    ph_cal[4] = 1'b1;  ph_ticks[4] = $urandom_range(4096, 128);
    ph_cal[5] = 1'b0;  ph_ticks[5] = UNIT_SCALE;

    for (int p = 0; p < N_PHASES; p++) begin
      // Sender-light idling first, then receiver-light, then none at all.
      if (p < 2) begin
        src_idle_pct = 12;
        dst_idle_pct = 56;
      end else if (p < 4) begin
        src_idle_pct = 56;
        dst_idle_pct = 12;
      end else begin
        src_idle_pct = 0;
        dst_idle_pct = 0;
      end
      apply_scale(ph_cal[p], SCALE_W'(ph_ticks[p]));
      // A long receiver hold-off in one idling phase and in the free-running
      // one, so that the block fills and stalls its input.
      run_phase(PHASE_ITEMS, (p == 1 || p == 4) ? 10 : -1);
      drain_positions();
    end

    // Let any stray result show itself before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("dead_reckoning_odometry_top_test: done, clean");
    end else begin
      $display("dead_reckoning_odometry_top_test: done, errors");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this time.
  initial begin
    #20_000_000;
    $display("dead_reckoning_odometry_top_test: done, errors");
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/dro_pkg.sv
sv/dro_cordic.sv
sv/dead_reckoning_odometry_top.sv
dv/dead_reckoning_odometry_top_test.sv
